// File: rtl/pcov_pkg.sv
// Shared types, constants and the glyph font table for the pixel coverage pipeline.
package pcov_pkg;

   localparam int DISPLAY_W = 720;
   localparam int DISPLAY_H = 1440;

   localparam int PIX_IDX_W = 20;
   localparam int REQ_DATA_W = 128;
   localparam int RSP_DATA_W = 56;

   localparam logic [1:0] ACT_RECT  = 2'd0;
   localparam logic [1:0] ACT_ROUND = 2'd1;
   localparam logic [1:0] ACT_GLYPH = 2'd2;

   localparam logic [7:0] CODE_FIRST = 8'd32;
   localparam logic [7:0] CODE_LAST  = 8'd126;

   localparam int GLYPH_COLS = 5;
   localparam int GLYPH_ROWS = 8;

   typedef logic signed [14:0] rel_type;

   typedef struct packed {
      logic [1:0]         action;
      logic [9:0]         pixel_x;
      logic [10:0]        pixel_y;
      logic signed [11:0] origin_x;
      logic signed [11:0] origin_y;
      logic [10:0]        box_width;
      logic [10:0]        box_height;
      logic [9:0]         corner_radius;
      logic [7:0]         char_code;
      logic [3:0]         glyph_scale;
      logic [31:0]        paint_color;
   } req_type;

   typedef struct packed {
      logic [1:0]                   action;
      logic                         on_display;
      logic [PIX_IDX_W-1:0]         index;
      logic [31:0]                  color;
      rel_type                      rx;
      rel_type                      ry;
      logic [10:0]                  w;
      logic [10:0]                  h;
      logic [9:0]                   r;
      logic [GLYPH_ROWS-1:0][6:0]   mults;
      logic                         glyph_ok;
      logic [39:0]                  glyph_cols;
   } s1_type;

   typedef struct packed {
      logic [1:0]           action;
      logic                 on_display;
      logic [PIX_IDX_W-1:0] index;
      logic [31:0]          color;
      logic                 in_box;
      logic [9:0]           dx;
      logic [9:0]           dy;
      logic [9:0]           r;
      logic                 glyph_in;
      logic [2:0]           col_rev;
      logic [2:0]           row;
      logic [39:0]          glyph_cols;
   } s2_type;

   typedef struct packed {
      logic [1:0]           action;
      logic                 on_display;
      logic [PIX_IDX_W-1:0] index;
      logic [31:0]          color;
      logic                 in_box;
      logic [19:0]          dx_sq;
      logic [19:0]          dy_sq;
      logic [19:0]          r_sq;
      logic                 glyph_hit;
   } s3_type;

   typedef struct packed {
      logic                 write_enable;
      logic [PIX_IDX_W-1:0] index;
      logic [31:0]          color;
   } rsp_type;

   localparam logic [39:0] GLYPH_ROM [0:94] = '{
      40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
      40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
      40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
      40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
      40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
      40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
      40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
      40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
      40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
      40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
      40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
      40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
      40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
      40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
      40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
      40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040,
      40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
      40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h0C5252523E,
      40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h7F10284400,
      40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
      40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
      40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
      40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
      40'h00007F0000, 40'h0041360800, 40'h08082A1C08
   };

   function automatic logic [39:0] glyph_columns(input logic [7:0] code);
      logic [7:0] offset;
      offset = code - CODE_FIRST;
      if (code < CODE_FIRST || code > CODE_LAST) begin
         return 40'h0;
      end
      return GLYPH_ROM[offset[6:0]];
   endfunction

endpackage

// File: rtl/primitive_pixel_coverage.sv
// Top level of the per-pixel rectangle, rounded rectangle and glyph coverage pipeline.
//
//   channel  direction  payload
//   req_     in         tuser: action; tdata: pixel_x .. paint_color
//   rsp_     out        tuser: write_enable; tdata: pixel_index, out_color
//
// One request per clock while rsp_tready is high; four register stages (setup,
// classify, square and output) lie between a request and its result.
// The rate is set by the four stage registers, each of which can take a new request
// every cycle unless the stage after it stalls; the square multipliers sit in stage three.
// Reset clears the stage valid bits only.
// A stall on rsp_tready fills empty stages first and then holds req_tready low.
module primitive_pixel_coverage (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [9:0] pixel_x, [20:10] pixel_y, [32:21] origin_x, [44:33] origin_y,
   // [55:45] box_width, [66:56] box_height, [76:67] corner_radius,
   // [84:77] char_code, [88:85] glyph_scale, [120:89] paint_color
   input  logic [pcov_pkg::REQ_DATA_W-1:0] req_tdata,
   // [1:0] action
   input  logic [1:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [19:0] pixel_index, [51:20] out_color
   output logic [pcov_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // [0] write_enable
   output logic [0:0]                      rsp_tuser
);

   pcov_pkg::req_type req;
   pcov_pkg::s1_type  s1;
   pcov_pkg::s2_type  s2;
   pcov_pkg::rsp_type rsp;
   logic              s1_valid;
   logic              s1_ready;
   logic              s2_valid;
   logic              s2_ready;

   always_comb begin
      req.action = req_tuser;
      req.pixel_x = req_tdata[9:0];
      req.pixel_y = req_tdata[20:10];
      req.origin_x = req_tdata[32:21];
      req.origin_y = req_tdata[44:33];
      req.box_width = req_tdata[55:45];
      req.box_height = req_tdata[66:56];
      req.corner_radius = req_tdata[76:67];
      req.char_code = req_tdata[84:77];
      req.glyph_scale = req_tdata[88:85];
      req.paint_color = req_tdata[120:89];
   end

   pcov_setup u_setup (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_req    (req),
      .out_valid (s1_valid),
      .out_ready (s1_ready),
      .out_stage (s1)
   );

   pcov_classify u_classify (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_stage  (s1),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .out_stage (s2)
   );

   pcov_resolve u_resolve (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_ready  (s2_ready),
      .in_stage  (s2),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_rsp   (rsp)
   );

   assign rsp_tdata = {4'b0, rsp.color, rsp.index};
   assign rsp_tuser = rsp.write_enable;

endmodule

// File: rtl/pcov_setup.sv
// First pipeline stage: relative coordinates, display check, index, glyph font fetch.
module pcov_setup (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  pcov_pkg::req_type in_req,
   output logic              out_valid,
   input  logic              out_ready,
   output pcov_pkg::s1_type  out_stage
);

   logic             valid_ff;
   pcov_pkg::s1_type s1_ff;
   pcov_pkg::s1_type s1_in;

   always_comb begin
      s1_in = '0;
      s1_in.action = in_req.action;
      s1_in.on_display = ({1'b0, in_req.pixel_x} < 11'(pcov_pkg::DISPLAY_W)) &&
                         ({1'b0, in_req.pixel_y} < 12'(pcov_pkg::DISPLAY_H));
      s1_in.index = pcov_pkg::PIX_IDX_W'(pcov_pkg::PIX_IDX_W'(in_req.pixel_y) *
                    pcov_pkg::PIX_IDX_W'(pcov_pkg::DISPLAY_W)) +
                    pcov_pkg::PIX_IDX_W'(in_req.pixel_x);
      s1_in.color = in_req.paint_color;
      s1_in.rx = pcov_pkg::rel_type'({1'b0, in_req.pixel_x}) -
                 pcov_pkg::rel_type'(in_req.origin_x);
      s1_in.ry = pcov_pkg::rel_type'({1'b0, in_req.pixel_y}) -
                 pcov_pkg::rel_type'(in_req.origin_y);
      s1_in.w = in_req.box_width;
      s1_in.h = in_req.box_height;
      s1_in.r = in_req.corner_radius;
      for (int k = 0; k < pcov_pkg::GLYPH_ROWS; k++) begin
         s1_in.mults[k] = 7'(in_req.glyph_scale) * 7'(k + 1);
      end
      s1_in.glyph_ok = (in_req.glyph_scale != 4'd0) &&
                       (in_req.char_code >= pcov_pkg::CODE_FIRST) &&
                       (in_req.char_code <= pcov_pkg::CODE_LAST);
      s1_in.glyph_cols = pcov_pkg::glyph_columns(in_req.char_code);
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         s1_ff <= s1_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_stage = s1_ff;

endmodule

// File: rtl/pcov_classify.sv
// Second pipeline stage: box test, corner zone distances, glyph dot column and row.
module pcov_classify (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  pcov_pkg::s1_type in_stage,
   output logic             out_valid,
   input  logic             out_ready,
   output pcov_pkg::s2_type out_stage
);

   logic             valid_ff;
   pcov_pkg::s2_type s2_ff;
   pcov_pkg::s2_type s2_in;

   pcov_pkg::rel_type ww;
   pcov_pkg::rel_type hh;
   pcov_pkg::rel_type rr;
   pcov_pkg::rel_type one;
   pcov_pkg::rel_type m5;
   pcov_pkg::rel_type m8;
   logic              zl;
   logic              zr;
   logic              zt;
   logic              zb;
   logic [9:0]        dx_l;
   logic [9:0]        dx_r;
   logic [9:0]        dy_t;
   logic [9:0]        dy_b;
   logic [2:0]        col;
   logic [2:0]        row;

   always_comb begin
      ww = pcov_pkg::rel_type'({1'b0, in_stage.w});
      hh = pcov_pkg::rel_type'({1'b0, in_stage.h});
      rr = pcov_pkg::rel_type'({1'b0, in_stage.r});
      one = pcov_pkg::rel_type'(1);
      m5 = pcov_pkg::rel_type'({1'b0, in_stage.mults[pcov_pkg::GLYPH_COLS-1]});
      m8 = pcov_pkg::rel_type'({1'b0, in_stage.mults[pcov_pkg::GLYPH_ROWS-1]});

      zl = in_stage.rx < rr;
      zr = (in_stage.rx + rr) >= ww;
      zt = in_stage.ry < rr;
      zb = (in_stage.ry + rr) >= hh;
      dx_l = 10'(rr - in_stage.rx);
      dx_r = 10'(in_stage.rx + rr + one - ww);
      dy_t = 10'(rr - in_stage.ry);
      dy_b = 10'(in_stage.ry + rr + one - hh);

      col = 3'd0;
      for (int k = 0; k < pcov_pkg::GLYPH_COLS - 1; k++) begin
         col = col + 3'(in_stage.rx >= pcov_pkg::rel_type'({1'b0, in_stage.mults[k]}));
      end
      row = 3'd0;
      for (int k = 0; k < pcov_pkg::GLYPH_ROWS - 1; k++) begin
         row = row + 3'(in_stage.ry >= pcov_pkg::rel_type'({1'b0, in_stage.mults[k]}));
      end

      s2_in = '0;
      s2_in.action = in_stage.action;
      s2_in.on_display = in_stage.on_display;
      s2_in.index = in_stage.index;
      s2_in.color = in_stage.color;
      s2_in.in_box = (in_stage.rx >= 0) && (in_stage.rx < ww) &&
                     (in_stage.ry >= 0) && (in_stage.ry < hh);
      s2_in.r = in_stage.r;
      if (zl && zt) begin
         s2_in.dx = dx_l;
         s2_in.dy = dy_t;
      end else if (zr && zt) begin
         s2_in.dx = dx_r;
         s2_in.dy = dy_t;
      end else if (zl && zb) begin
         s2_in.dx = dx_l;
         s2_in.dy = dy_b;
      end else if (zr && zb) begin
         s2_in.dx = dx_r;
         s2_in.dy = dy_b;
      end else begin
         s2_in.dx = 10'd0;
         s2_in.dy = 10'd0;
      end
      s2_in.glyph_in = in_stage.glyph_ok &&
                       (in_stage.rx >= 0) && (in_stage.rx < m5) &&
                       (in_stage.ry >= 0) && (in_stage.ry < m8);
      s2_in.col_rev = 3'(pcov_pkg::GLYPH_COLS - 1) - col;
      s2_in.row = row;
      s2_in.glyph_cols = in_stage.glyph_cols;
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         s2_ff <= s2_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_stage = s2_ff;

   assert property (@(posedge clock) disable iff (reset)
      valid_ff && s2_ff.in_box && (s2_ff.action == pcov_pkg::ACT_ROUND) |->
      (s2_ff.dx <= s2_ff.r) && (s2_ff.dy <= s2_ff.r))
      else $error("corner distance exceeds radius inside box");

   assert property (@(posedge clock) disable iff (reset)
      valid_ff && s2_ff.glyph_in |-> (s2_ff.col_rev < 3'(pcov_pkg::GLYPH_COLS)))
      else $error("glyph column out of range");

endmodule

// File: rtl/pcov_resolve.sv
// Third and fourth pipeline stages: squares, glyph bit pick, final decision and output register.
module pcov_resolve (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  pcov_pkg::s2_type  in_stage,
   output logic              out_valid,
   input  logic              out_ready,
   output pcov_pkg::rsp_type out_rsp
);

   logic              s3_valid_ff;
   pcov_pkg::s3_type  s3_ff;
   pcov_pkg::s3_type  s3_in;
   logic              s3_ready;
   logic              rsp_valid_ff;
   pcov_pkg::rsp_type rsp_ff;
   pcov_pkg::rsp_type rsp_in;
   logic              rsp_ready;
   logic              hit;

   always_comb begin
      s3_in = '0;
      s3_in.action = in_stage.action;
      s3_in.on_display = in_stage.on_display;
      s3_in.index = in_stage.index;
      s3_in.color = in_stage.color;
      s3_in.in_box = in_stage.in_box;
      s3_in.dx_sq = 20'(in_stage.dx) * 20'(in_stage.dx);
      s3_in.dy_sq = 20'(in_stage.dy) * 20'(in_stage.dy);
      s3_in.r_sq = 20'(in_stage.r) * 20'(in_stage.r);
      s3_in.glyph_hit = in_stage.glyph_in &&
                        in_stage.glyph_cols[{in_stage.col_rev, in_stage.row}];
   end

   always_comb begin
      case (s3_ff.action)
         pcov_pkg::ACT_RECT:  hit = s3_ff.in_box;
         pcov_pkg::ACT_ROUND: hit = s3_ff.in_box &&
                                    ((21'(s3_ff.dx_sq) + 21'(s3_ff.dy_sq)) <=
                                     21'(s3_ff.r_sq));
         pcov_pkg::ACT_GLYPH: hit = s3_ff.glyph_hit;
         default:             hit = 1'b0;
      endcase
      rsp_in.write_enable = hit && s3_ff.on_display;
      rsp_in.index = rsp_in.write_enable ? s3_ff.index : '0;
      rsp_in.color = rsp_in.write_enable ? s3_ff.color : '0;
   end

   assign rsp_ready = !rsp_valid_ff || out_ready;
   assign s3_ready = !s3_valid_ff || rsp_ready;
   assign in_ready = s3_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s3_ready) begin
            s3_valid_ff <= in_valid;
         end
         if (rsp_ready) begin
            rsp_valid_ff <= s3_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s3_ready && in_valid) begin
         s3_ff <= s3_in;
      end
      if (rsp_ready && s3_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = rsp_valid_ff;
   assign out_rsp = rsp_ff;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.write_enable |-> (rsp_ff.index == '0) && (rsp_ff.color == '0))
      else $error("idle response carries nonzero payload");

   assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff && rsp_ready |=> rsp_valid_ff)
      else $error("request lost between decision and output stage");

   assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff && !s3_ready |=> s3_valid_ff && $stable(s3_ff))
      else $error("square stage changed while stalled");

endmodule

// File: dv/tb.sv
// Self-checking testbench for the rectangle, rounded rectangle and glyph pixel coverage pipeline.
module tb;

   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 450;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 8;

   localparam logic [39:0] GLYPH_BITMAP [95] = '{
      40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
      40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
      40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
      40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
      40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
      40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
      40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
      40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
      40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
      40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
      40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
      40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
      40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
      40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
      40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
      40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040,
      40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
      40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h0C5252523E,
      40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h7F10284400,
      40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
      40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
      40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
      40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
      40'h00007F0000, 40'h0041360800, 40'h08082A1C08
   };

   class pixel_write_board;
      pcov_pkg::rsp_type pending_writes[$];
      int errors;

      function new();
         errors = 0;
      endfunction

      static function bit in_rect(int x, int y, int ox, int oy, int w, int h);
         return x >= ox && x < ox + w && y >= oy && y < oy + h;
      endfunction

      function pcov_pkg::rsp_type predict_write(pcov_pkg::req_type rq);
         int x, y, ox, oy, w, h, r, s, rx, ry;
         int left, right, top, bottom, dx, dy, col, row;
         logic [39:0] cols;
         bit hit;
         pcov_pkg::rsp_type wr;
         x = rq.pixel_x;
         y = rq.pixel_y;
         ox = $signed(rq.origin_x);
         oy = $signed(rq.origin_y);
         w = rq.box_width;
         h = rq.box_height;
         r = rq.corner_radius;
         s = rq.glyph_scale;
         hit = 1'b0;
         if (x < pcov_pkg::DISPLAY_W && y < pcov_pkg::DISPLAY_H) begin
            case (rq.action)
               pcov_pkg::ACT_RECT: begin
                  hit = in_rect(x, y, ox, oy, w, h);
               end
               pcov_pkg::ACT_ROUND: begin
                  if (in_rect(x, y, ox, oy, w, h)) begin
                     left = ox + r;
                     right = ox + w - r;
                     top = oy + r;
                     bottom = oy + h - r;
                     dx = 0;
                     dy = 0;
                     if (x < left && y < top) begin
                        dx = left - x;
                        dy = top - y;
                     end else if (x >= right && y < top) begin
                        dx = x - (right - 1);
                        dy = top - y;
                     end else if (x < left && y >= bottom) begin
                        dx = left - x;
                        dy = y - (bottom - 1);
                     end else if (x >= right && y >= bottom) begin
                        dx = x - (right - 1);
                        dy = y - (bottom - 1);
                     end
                     hit = dx * dx + dy * dy <= r * r;
                  end
               end
               pcov_pkg::ACT_GLYPH: begin
                  rx = x - ox;
                  ry = y - oy;
                  if (s > 0 && rq.char_code >= pcov_pkg::CODE_FIRST &&
                      rq.char_code <= pcov_pkg::CODE_LAST &&
                      rx >= 0 && rx < pcov_pkg::GLYPH_COLS * s &&
                      ry >= 0 && ry < pcov_pkg::GLYPH_ROWS * s) begin
                     col = rx / s;
                     row = ry / s;
                     cols = GLYPH_BITMAP[rq.char_code - pcov_pkg::CODE_FIRST];
                     hit = cols[32 - 8 * col + row];
                  end
               end
               default: begin
                  hit = 1'b0;
               end
            endcase
         end
         wr.write_enable = hit;
         wr.index = hit ? pcov_pkg::PIX_IDX_W'(y * pcov_pkg::DISPLAY_W + x) : '0;
         wr.color = hit ? rq.paint_color : '0;
         return wr;
      endfunction

      function void note_pixel(pcov_pkg::req_type rq);
         pending_writes.push_back(predict_write(rq));
      endfunction

      function void check_write(logic we, logic [pcov_pkg::PIX_IDX_W-1:0] idx,
                                logic [31:0] color);
         pcov_pkg::rsp_type wr;
         if (pending_writes.size() == 0) begin
            $error("response with no request pending: write_enable %0d index %0d color %h",
                   we, idx, color);
            errors++;
            return;
         end
         wr = pending_writes.pop_front();
         if (we !== wr.write_enable) begin
            $error("write_enable: expected %0d, got %0d", wr.write_enable, we);
            errors++;
         end
         if (idx !== wr.index) begin
            $error("pixel_index: expected %0d, got %0d", wr.index, idx);
            errors++;
         end
         if (color !== wr.color) begin
            $error("out_color: expected %h, got %h", wr.color, color);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [pcov_pkg::REQ_DATA_W-1:0] req_tdata;
   logic [1:0] req_tuser;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [pcov_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [0:0] rsp_tuser;

   pixel_write_board board;
   int cycle_count = 0;
   bit steady = 1'b0;

   primitive_pixel_coverage u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         board.check_write(rsp_tuser[0], rsp_tdata[19:0], rsp_tdata[51:20]);
      end
      rsp_tready <= steady || $urandom_range(99) >= 10;
   end

   function automatic pcov_pkg::req_type make_req(logic [1:0] act, int px, int py, int ox,
                                                  int oy, int w, int h, int r, int code,
                                                  int s, logic [31:0] color);
      pcov_pkg::req_type rq;
      rq.action = act;
      rq.pixel_x = 10'(px);
      rq.pixel_y = 11'(py);
      rq.origin_x = 12'(ox);
      rq.origin_y = 12'(oy);
      rq.box_width = 11'(w);
      rq.box_height = 11'(h);
      rq.corner_radius = 10'(r);
      rq.char_code = 8'(code);
      rq.glyph_scale = 4'(s);
      rq.paint_color = color;
      return rq;
   endfunction

   function automatic pcov_pkg::req_type random_request();
      pcov_pkg::req_type rq;
      logic [127:0] noise;
      int roll, w, h, s, ext_x, ext_y, ox, oy, px, py;
      roll = $urandom_range(99);
      if (roll < 15) begin
         noise = {$urandom, $urandom, $urandom, $urandom};
         rq = noise[120:0];
         return rq;
      end
      rq.action = 2'($urandom_range(2));
      rq.paint_color = $urandom;
      w = (roll < 20) ? $urandom_range(2047) : $urandom_range(48);
      h = (roll < 20) ? $urandom_range(2047) : $urandom_range(48);
      s = (roll < 24) ? $urandom_range(15) : $urandom_range(1, 4);
      rq.box_width = 11'(w);
      rq.box_height = 11'(h);
      rq.glyph_scale = 4'(s);
      rq.char_code = (roll < 28) ? 8'($urandom) :
                     8'($urandom_range(pcov_pkg::CODE_FIRST, pcov_pkg::CODE_LAST));
      rq.corner_radius = (roll < 32) ? 10'($urandom) :
                         10'($urandom_range(((w < h) ? w : h) / 2 + 2));
      ext_x = (rq.action == pcov_pkg::ACT_GLYPH) ? pcov_pkg::GLYPH_COLS * s : w;
      ext_y = (rq.action == pcov_pkg::ACT_GLYPH) ? pcov_pkg::GLYPH_ROWS * s : h;
      ox = int'($urandom_range(800)) - 40;
      oy = int'($urandom_range(1520)) - 40;
      px = ox + int'($urandom_range(ext_x + 3)) - 2;
      py = oy + int'($urandom_range(ext_y + 3)) - 2;
      rq.origin_x = 12'(ox);
      rq.origin_y = 12'(oy);
      rq.pixel_x = 10'(px);
      rq.pixel_y = 11'(py);
      return rq;
   endfunction

   task automatic push_request(pcov_pkg::req_type rq);
      if (!steady && $urandom_range(99) < 10) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= rq.action;
      req_tdata <= {7'd0, rq.paint_color, rq.glyph_scale, rq.char_code, rq.corner_radius,
                    rq.box_height, rq.box_width, rq.origin_y, rq.origin_x,
                    rq.pixel_y, rq.pixel_x};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_pixel(rq);
   endtask

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      pcov_pkg::req_type directed[$];
      board = new();
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= pcov_pkg::ACT_RECT;

      directed.push_back(make_req(pcov_pkg::ACT_RECT, 0, 0, 0, 0, 1, 1, 0, 0, 1,
                                  32'h0000_0001));
      directed.push_back(make_req(pcov_pkg::ACT_RECT, 10, 5, 0, 0, 10, 10, 0, 0, 1,
                                  32'h1234_5678));
      directed.push_back(make_req(pcov_pkg::ACT_RECT, 0, 0, -2048, -2048, 2047, 2047, 0, 0,
                                  1, '1));
      directed.push_back(make_req(pcov_pkg::ACT_RECT, 719, 1439, -100, -100, 2047, 2047, 0,
                                  0, 1, '1));
      directed.push_back(make_req(pcov_pkg::ACT_RECT, 1023, 100, 0, 0, 2047, 2047, 0, 0, 1,
                                  '1));
      directed.push_back(make_req(pcov_pkg::ACT_RECT, 100, 2047, 0, 0, 2047, 2047, 0, 0, 1,
                                  '1));
      directed.push_back(make_req(pcov_pkg::ACT_RECT, 720, 1440, 0, 0, 2047, 2047, 0, 0, 1,
                                  '1));
      directed.push_back(make_req(pcov_pkg::ACT_RECT, 5, 5, 0, 0, 0, 20, 0, 0, 1, '1));
      directed.push_back(make_req(pcov_pkg::ACT_RECT, 5, 5, 0, 0, 20, 0, 0, 0, 1, '1));
      directed.push_back(make_req(pcov_pkg::ACT_RECT, 700, 1400, 2047, 2047, 2047, 2047, 0,
                                  0, 1, '1));
      directed.push_back(make_req(pcov_pkg::ACT_ROUND, 0, 0, 0, 0, 20, 20, 0, 0, 1,
                                  32'hCAFE_F00D));
      directed.push_back(make_req(pcov_pkg::ACT_ROUND, 0, 0, 0, 0, 20, 20, 5, 0, 1,
                                  32'hCAFE_F00D));
      directed.push_back(make_req(pcov_pkg::ACT_ROUND, 1, 4, 0, 0, 20, 20, 5, 0, 1,
                                  32'hCAFE_F00D));
      directed.push_back(make_req(pcov_pkg::ACT_ROUND, 19, 18, 0, 0, 20, 20, 5, 0, 1,
                                  32'h8000_0000));
      directed.push_back(make_req(pcov_pkg::ACT_ROUND, 4, 6, 0, 0, 8, 8, 10, 0, 1,
                                  32'h0F0F_0F0F));
      directed.push_back(make_req(pcov_pkg::ACT_ROUND, 7, 7, 0, 0, 8, 8, 10, 0, 1,
                                  32'hF0F0_F0F0));
      directed.push_back(make_req(pcov_pkg::ACT_ROUND, 300, 700, -500, -300, 2047, 2047,
                                  1023, 0, 1, '1));
      directed.push_back(make_req(pcov_pkg::ACT_GLYPH, 10, 21, 10, 20, 0, 0, 0, 65, 1,
                                  32'hFF00_00FF));
      directed.push_back(make_req(pcov_pkg::ACT_GLYPH, 24, 119, 10, 0, 0, 0, 0, 65, 15,
                                  32'hFF00_00FF));
      directed.push_back(make_req(pcov_pkg::ACT_GLYPH, 10, 21, 10, 20, 0, 0, 0, 65, 0,
                                  32'hFF00_00FF));
      directed.push_back(make_req(pcov_pkg::ACT_GLYPH, 12, 22, 10, 20, 0, 0, 0, 31, 1, '1));
      directed.push_back(make_req(pcov_pkg::ACT_GLYPH, 12, 22, 10, 20, 0, 0, 0, 127, 1, '1));
      directed.push_back(make_req(pcov_pkg::ACT_GLYPH, 12, 22, 10, 20, 0, 0, 0, 255, 1, '1));
      directed.push_back(make_req(pcov_pkg::ACT_GLYPH, 12, 22, 10, 20, 0, 0, 0, 32, 1, '1));
      directed.push_back(make_req(pcov_pkg::ACT_GLYPH, 12, 23, 10, 20, 0, 0, 0, 126, 1, '1));
      directed.push_back(make_req(ACT_UNUSED, 5, 5, 0, 0, 20, 20, 0, 65, 1, '1));

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) begin
         push_request(directed[i]);
      end
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         steady = n >= 150 && n < 250;
         push_request(random_request());
      end
      steady = 1'b0;
      req_tvalid <= 1'b0;

      while (board.pending_writes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
